@@ rtl/log_compress_pixel_assert.svh @@
// Assertion macros shared by the log compression RTL.
`ifndef LOG_COMPRESS_PIXEL_ASSERT_SVH
`define LOG_COMPRESS_PIXEL_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define LCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("log compression check failed");

// Check that cons holds in the cycle after ante holds.
`define LCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("log compression check failed");

`endif

@@ rtl/lc_pkg.sv @@
// Shared constants and types of the log compression pipeline.
`default_nettype none

package lc_pkg;

  // Field and register widths
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int GAIN_W          = 32;
  localparam int RANGE_W         = 16;
  localparam int PIX_W           = 8;
  localparam int PROD_W_DEF      = GAIN_W + SAMPLE_BITS_DEF;
  localparam int EXP_W_DEF       = $clog2(PROD_W_DEF);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 2'd2;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 32'h0001_0000;
  localparam logic [GAIN_W-1:0]  NORM_RST  = 32'h0001_0000;
  localparam logic [RANGE_W-1:0] RANGE_RST = 16'd15360;

  // Log2 datapath
  localparam int MANT_W = 32;
  localparam int FRAC_W = 16;

  // 20*log10(2) dB per octave in Q16
  localparam int DBO_W = 19;
  localparam logic [DBO_W-1:0] DB_PER_OCT_Q16 = 19'd394566;

  // Divisor is range << 24 after the common factor 256 is taken out
  localparam int DEN_SHIFT = 24;
  localparam int DEN_W     = RANGE_W + DEN_SHIFT;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Two log lanes: scaled sample and reference level
  localparam int LANES  = 2;
  localparam int LANE_X = 0;
  localparam int LANE_N = 1;

  // Control that travels with each request
  typedef struct packed {
    logic valid;
    logic zero_x;
    logic zero_n;
  } lc_ctl_t;

endpackage

`default_nettype wire

@@ rtl/lc_norm.sv @@
// Leading-one search and mantissa normalization, three stages, two lanes.
`default_nettype none

module lc_norm
  import lc_pkg::*;
#(
  parameter int W     = PROD_W_DEF,
  parameter int EXP_W = EXP_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  lc_ctl_t                          ctl_in,
  input  logic [LANES-1:0][W-1:0]          val_in,
  output lc_ctl_t                          ctl_out,
  output logic [LANES-1:0][EXP_W-1:0]      exp_out,
  output logic [LANES-1:0][MANT_W-1:0]     mant_out
);

  localparam int NBYTES = (W + 7) / 8;
  localparam int WP     = NBYTES * 8;

  // Index of the top set bit of one byte
  function automatic logic [2:0] top_bit8(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  lc_ctl_t ctl1_r, ctl2_r, ctl3_r;
  logic [LANES-1:0][WP-1:0]            val1_r, val1_nxt, val2_r;
  logic [LANES-1:0][NBYTES-1:0]        nz1_r, nz1_nxt;
  logic [LANES-1:0][NBYTES-1:0][2:0]   top1_r, top1_nxt;
  logic [LANES-1:0][EXP_W-1:0]         exp2_r, exp2_nxt, exp3_r;
  logic [LANES-1:0][MANT_W-1:0]        mant3_r, mant3_nxt;

  // Stage 1: per-byte nonzero flag and top bit
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      val1_nxt[l] = WP'(val_in[l]);
      for (int b = 0; b < NBYTES; b++) begin
        nz1_nxt[l][b]  = |val1_nxt[l][b*8 +: 8];
        top1_nxt[l][b] = top_bit8(val1_nxt[l][b*8 +: 8]);
      end
    end
  end

  // Stage 2: pick the highest nonzero byte
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      exp2_nxt[l] = '0;
      for (int b = 0; b < NBYTES; b++) begin
        if (nz1_r[l][b]) exp2_nxt[l] = EXP_W'(b * 8) | EXP_W'(top1_r[l][b]);
      end
    end
  end

  // Stage 3: shift the top set bit to bit 31
  always_comb begin
    logic [WP+MANT_W-1:0] ext;
    logic [WP+MANT_W-1:0] sh;
    ext = '0;
    sh  = '0;
    for (int l = 0; l < LANES; l++) begin
      ext          = {val2_r[l], {MANT_W{1'b0}}};
      sh           = ext >> ({1'b0, exp2_r[l]} + 1'b1);
      mant3_nxt[l] = sh[MANT_W-1:0];
    end
  end

  // Control: valid bits cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (adv) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  // Payload: advance with the pipe
  always_ff @(posedge clk) begin
    if (adv) begin
      val1_r  <= val1_nxt;
      nz1_r   <= nz1_nxt;
      top1_r  <= top1_nxt;
      val2_r  <= val1_r;
      exp2_r  <= exp2_nxt;
      exp3_r  <= exp2_r;
      mant3_r <= mant3_nxt;
    end
  end

  assign ctl_out  = ctl3_r;
  assign exp_out  = exp3_r;
  assign mant_out = mant3_r;

endmodule

`default_nettype wire

@@ rtl/lc_frac.sv @@
// Fractional log2 by repeated squaring, one fraction bit per stage, two lanes.
`default_nettype none
`include "log_compress_pixel_assert.svh"

module lc_frac
  import lc_pkg::*;
#(
  parameter int EXP_W = EXP_W_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  lc_ctl_t                              ctl_in,
  input  logic [LANES-1:0][EXP_W-1:0]          exp_in,
  input  logic [LANES-1:0][MANT_W-1:0]         mant_in,
  output lc_ctl_t                              ctl_out,
  output logic [LANES-1:0][EXP_W+FRAC_W-1:0]   log_out
);

  lc_ctl_t                        ctl_r   [FRAC_W];
  lc_ctl_t                        src_ctl [FRAC_W];
  logic [LANES-1:0][MANT_W-1:0]   m_r     [FRAC_W];
  logic [LANES-1:0][MANT_W-1:0]   m_nxt   [FRAC_W];
  logic [LANES-1:0][MANT_W-1:0]   src_m   [FRAC_W];
  logic [LANES-1:0][FRAC_W-1:0]   f_r     [FRAC_W];
  logic [LANES-1:0][FRAC_W-1:0]   f_nxt   [FRAC_W];
  logic [LANES-1:0][FRAC_W-1:0]   src_f   [FRAC_W];
  logic [LANES-1:0][EXP_W-1:0]    e_r     [FRAC_W];
  logic [LANES-1:0][EXP_W-1:0]    src_e   [FRAC_W];
  logic                           chk_x, chk_n;

  // Feed each stage from the one before it
  always_comb begin
    src_ctl[0] = ctl_in;
    src_m[0]   = mant_in;
    src_f[0]   = '0;
    src_e[0]   = exp_in;
    for (int k = 1; k < FRAC_W; k++) begin
      src_ctl[k] = ctl_r[k-1];
      src_m[k]   = m_r[k-1];
      src_f[k]   = f_r[k-1];
      src_e[k]   = e_r[k-1];
    end
  end

  // Square the mantissa; an overflow past 2.0 yields a one bit and a halving
  always_comb begin
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    logic                hi;
    sq = '0;
    t  = '0;
    hi = 1'b0;
    for (int k = 0; k < FRAC_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        sq          = src_m[k][l] * src_m[k][l];
        t           = sq[2*MANT_W-1:MANT_W-1];
        hi          = t[MANT_W];
        m_nxt[k][l] = hi ? t[MANT_W:1] : t[MANT_W-1:0];
        f_nxt[k][l] = {src_f[k][l][FRAC_W-2:0], hi};
      end
    end
  end

  // Control: valid bits cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FRAC_W; k++) ctl_r[k] <= '0;
    end else if (adv) begin
      for (int k = 0; k < FRAC_W; k++) ctl_r[k] <= src_ctl[k];
    end
  end

  // Payload: advance with the pipe
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < FRAC_W; k++) begin
        m_r[k] <= m_nxt[k];
        f_r[k] <= f_nxt[k];
        e_r[k] <= src_e[k];
      end
    end
  end

  assign ctl_out = ctl_r[FRAC_W-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      log_out[l] = {e_r[FRAC_W-1][l], f_r[FRAC_W-1][l]};
    end
  end

  // Lanes that carry a nonzero operand at the last stage
  assign chk_x = ctl_r[FRAC_W-1].valid && !ctl_r[FRAC_W-1].zero_x;
  assign chk_n = ctl_r[FRAC_W-1].valid && !ctl_r[FRAC_W-1].zero_n;

  // A nonzero operand still has a normalized mantissa after the last squaring
  `LCP_ASSERT_NOW(a_mant_norm_x, clk, rst_n, chk_x, m_r[FRAC_W-1][LANE_X][MANT_W-1])
  `LCP_ASSERT_NOW(a_mant_norm_n, clk, rst_n, chk_n, m_r[FRAC_W-1][LANE_N][MANT_W-1])

endmodule

`default_nettype wire

@@ rtl/lc_map.sv @@
// Map the log ratio to a grey level: scale, range compare, 8-stage divide.
`default_nettype none

module lc_map
  import lc_pkg::*;
#(
  parameter int EXP_W = EXP_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  lc_ctl_t                   ctl_in,
  input  logic [EXP_W+FRAC_W-1:0]   log_x,
  input  logic [EXP_W+FRAC_W-1:0]   log_n,
  input  logic [RANGE_W-1:0]        range_db,
  output logic                      pix_valid,
  output logic [PIX_W-1:0]          pix_value
);

  localparam int LOG_W = EXP_W + FRAC_W;
  localparam int A_W   = DBO_W + LOG_W;
  localparam int CMP_W = ((A_W > DEN_W) ? A_W : DEN_W) + 1;
  localparam int NUM_W = DEN_W + PIX_W;
  localparam int DIV_N = PIX_W;

  typedef enum logic [1:0] {
    SAT_NONE,
    SAT_LOW,
    SAT_HIGH
  } sat_t;

  typedef struct packed {
    logic valid;
    sat_t sat;
  } map_ctl_t;

  map_ctl_t               mc1_r, mc1_nxt, mc2_r, mc3_r, mc3_nxt, mc4_r;
  logic [LOG_W-1:0]       mag1_r, mag1_nxt;
  logic [A_W-1:0]         a2_r, a2_nxt;
  logic [DEN_W-1:0]       b3_r, b3_nxt;
  logic [NUM_W-1:0]       n4_r, n4_nxt;
  logic [DEN_W-1:0]       den;
  logic [CMP_W-1:0]       diff3;

  map_ctl_t               dc_r    [DIV_N];
  map_ctl_t               src_dc  [DIV_N];
  logic [NUM_W-1:0]       rem_r   [DIV_N];
  logic [NUM_W-1:0]       rem_nxt [DIV_N];
  logic [NUM_W-1:0]       src_rem [DIV_N];
  logic [PIX_W-1:0]       q_r     [DIV_N];
  logic [PIX_W-1:0]       q_nxt   [DIV_N];
  logic [PIX_W-1:0]       src_q   [DIV_N];

  // Divisor: range << 24, a zero range acts as one step
  assign den = {((range_db == '0) ? RANGE_W'(1) : range_db), {DEN_SHIFT{1'b0}}};

  // Stage 1: octave difference and early saturation
  always_comb begin
    mag1_nxt      = log_n - log_x;
    mc1_nxt.valid = ctl_in.valid;
    if (ctl_in.zero_x) begin
      mc1_nxt.sat = SAT_LOW;
    end else if (ctl_in.zero_n || (log_n <= log_x)) begin
      mc1_nxt.sat = SAT_HIGH;
    end else begin
      mc1_nxt.sat = SAT_NONE;
    end
  end

  // Stage 2: octaves to dB
  assign a2_nxt = mag1_r * DB_PER_OCT_Q16;

  // Stage 3: distance from the bottom of the range, clamp below it
  always_comb begin
    diff3   = CMP_W'(den) - CMP_W'(a2_r);
    b3_nxt  = diff3[DEN_W-1:0];
    mc3_nxt = mc2_r;
    if ((mc2_r.sat == SAT_NONE) && diff3[CMP_W-1]) mc3_nxt.sat = SAT_LOW;
  end

  // Stage 4: times 255
  assign n4_nxt = (NUM_W'(b3_r) << PIX_W) - NUM_W'(b3_r);

  // Divide stages: one quotient bit each, most significant first
  always_comb begin
    logic [NUM_W:0] trial;
    trial      = '0;
    src_dc[0]  = mc4_r;
    src_rem[0] = n4_r;
    src_q[0]   = '0;
    for (int j = 1; j < DIV_N; j++) begin
      src_dc[j]  = dc_r[j-1];
      src_rem[j] = rem_r[j-1];
      src_q[j]   = q_r[j-1];
    end
    for (int j = 0; j < DIV_N; j++) begin
      trial      = {1'b0, src_rem[j]} - ({1'b0, NUM_W'(den)} << (DIV_N - 1 - j));
      rem_nxt[j] = trial[NUM_W] ? src_rem[j] : trial[NUM_W-1:0];
      q_nxt[j]   = {src_q[j][PIX_W-2:0], !trial[NUM_W]};
    end
  end

  // Control: valid bits cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc1_r <= '0;
      mc2_r <= '0;
      mc3_r <= '0;
      mc4_r <= '0;
      for (int j = 0; j < DIV_N; j++) dc_r[j] <= '0;
    end else if (adv) begin
      mc1_r <= mc1_nxt;
      mc2_r <= mc1_r;
      mc3_r <= mc3_nxt;
      mc4_r <= mc3_r;
      for (int j = 0; j < DIV_N; j++) dc_r[j] <= src_dc[j];
    end
  end

  // Payload: advance with the pipe
  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r <= mag1_nxt;
      a2_r   <= a2_nxt;
      b3_r   <= b3_nxt;
      n4_r   <= n4_nxt;
      for (int j = 0; j < DIV_N; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
      end
    end
  end

  // Resolve saturation at the pipe exit
  assign pix_valid = dc_r[DIV_N-1].valid;

  always_comb begin
    case (dc_r[DIV_N-1].sat)
      SAT_LOW:  pix_value = '0;
      SAT_HIGH: pix_value = PIX_MAX;
      SAT_NONE: pix_value = q_r[DIV_N-1];
      default:  pix_value = q_r[DIV_N-1];
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/log_compress_pixel.sv @@
// Top level: config registers, gain multiply, log pipeline and output skid.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in_     | in  | in_tvalid/in_tready   | in_tdata: sample
//  out_    | out | out_tvalid/out_tready | out_tdata: pixel_value
//  cfg_    | in  | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One sample enters per clock while the skid is empty; each log2 stage holds one
// squaring multiplier per lane, each divide stage one compare-subtract, so
// throughput is one pixel per cycle unless the output stalls. From accept to
// out_tvalid: input, multiply, three normalize stages, sixteen log2 squaring
// stages, four scaling stages, eight divide stages and the output register.
// Reset is synchronous; it clears the valid bits and loads the register
// defaults. A full skid register stalls the whole pipe, nothing is lost.
`default_nettype none
`include "log_compress_pixel_assert.svh"

module log_compress_pixel
  import lc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // fields from bit 0: sample[SAMPLE_BITS-1:0], then zero fill
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // fields from bit 0: pixel_value[7:0]
  output logic [PIX_W-1:0]                       out_tdata,
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_wdata
);

  localparam int PROD_W = GAIN_W + SAMPLE_BITS;
  localparam int EXP_W  = $clog2(PROD_W);
  localparam int LOG_W  = EXP_W + FRAC_W;

  logic [GAIN_W-1:0]             gain_r, norm_r;
  logic [RANGE_W-1:0]            range_r;

  logic                          adv;
  lc_ctl_t                       ctl0_r, ctl0_nxt, ctl1_r;
  logic [SAMPLE_BITS-1:0]        samp0_r;
  logic [PROD_W-1:0]             prod1_r, prod1_nxt;
  logic [LANES-1:0][PROD_W-1:0]  norm_val;

  lc_ctl_t                       ctl_n, ctl_f;
  logic [LANES-1:0][EXP_W-1:0]   exp_n;
  logic [LANES-1:0][MANT_W-1:0]  mant_n;
  logic [LANES-1:0][LOG_W-1:0]   log_f;

  logic                          pix_valid;
  logic [PIX_W-1:0]              pix_value;
  logic                          push;
  logic                          out_valid_r, skid_valid_r;
  logic [PIX_W-1:0]              out_data_r, skid_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RST;
      norm_r  <= NORM_RST;
      range_r <= RANGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN:  gain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_NORM:  norm_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_RANGE: range_r <= cfg_wdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipe advances unless the skid register is holding a pixel
  assign adv       = !skid_valid_r;
  assign in_tready = adv;

  // Stage 0: capture the request and flag zero operands
  always_comb begin
    ctl0_nxt.valid  = in_tvalid;
    ctl0_nxt.zero_x = (gain_r == '0) || (in_tdata[SAMPLE_BITS-1:0] == '0);
    ctl0_nxt.zero_n = (norm_r == '0);
  end

  // Stage 1: gain times sample
  assign prod1_nxt = gain_r * samp0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
      ctl1_r <= '0;
    end else if (adv) begin
      ctl0_r <= ctl0_nxt;
      ctl1_r <= ctl0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      samp0_r <= in_tdata[SAMPLE_BITS-1:0];
      prod1_r <= prod1_nxt;
    end
  end

  // Lanes: scaled sample and reference level
  always_comb begin
    norm_val[LANE_X] = prod1_r;
    norm_val[LANE_N] = PROD_W'(norm_r);
  end

  lc_norm #(
    .W     (PROD_W),
    .EXP_W (EXP_W)
  ) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .ctl_in   (ctl1_r),
    .val_in   (norm_val),
    .ctl_out  (ctl_n),
    .exp_out  (exp_n),
    .mant_out (mant_n)
  );

  lc_frac #(
    .EXP_W (EXP_W)
  ) u_frac (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_in  (ctl_n),
    .exp_in  (exp_n),
    .mant_in (mant_n),
    .ctl_out (ctl_f),
    .log_out (log_f)
  );

  lc_map #(
    .EXP_W (EXP_W)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl_in    (ctl_f),
    .log_x     (log_f[LANE_X]),
    .log_n     (log_f[LANE_N]),
    .range_db  (range_r),
    .pix_valid (pix_valid),
    .pix_value (pix_value)
  );

  // Output register with skid: drain skid first, else take the pipe exit
  assign push = adv && pix_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : pix_value;
    end else if (push) begin
      skid_data_r <= pix_value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Skid only fills behind a stalled output and drains as soon as it moves
  `LCP_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `LCP_ASSERT_NEXT(a_skid_needs_stall, clk, rst_n, !out_valid_r, !skid_valid_r)
  `LCP_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_r && out_tready, !skid_valid_r && out_valid_r)

endmodule

`default_nettype wire

@@ tb/sv/log_compress_pixel_test.sv @@
// Self-checking testbench for the log compression pixel block.
`timescale 1ns / 100ps

module log_compress_pixel_test
  import lc_pkg::*;
();

  localparam int SAMPLE_W = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint DB_OCTAVE_Q16 = 394566;
  localparam int MAX_SHOWN = 10;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PIXEL,
    ROW_CHECK
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [31:0]            value;
    logic [PIX_W-1:0]       pixel;
  } row_t;

  // Directed part: register writes, samples checked by the predictor,
  // and samples whose grey level is obvious
  localparam row_t PLAN [33] = '{
    '{ROW_CHECK, CFG_GAIN,  32'h0000_0000, 8'd0},
    '{ROW_CHECK, CFG_GAIN,  32'h0000_0001, 8'd255},
    '{ROW_CHECK, CFG_GAIN,  32'h00FF_FFFF, 8'd255},
    '{ROW_WRITE, CFG_NORM,  32'hFFFF_FFFF, 8'd0},
    '{ROW_CHECK, CFG_GAIN,  32'h0000_0001, 8'd0},
    '{ROW_CHECK, CFG_GAIN,  32'h00FF_FFFF, 8'd255},
    '{ROW_PIXEL, CFG_GAIN,  32'h0000_0800, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h0000_FFFF, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h00AA_AAAA, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h0055_5555, 8'd0},
    '{ROW_WRITE, CFG_RANGE, 32'h0000_FFFF, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h0000_0001, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h0000_0100, 8'd0},
    '{ROW_WRITE, CFG_RANGE, 32'h0000_0000, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h0001_0000, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h0000_FFFF, 8'd0},
    '{ROW_WRITE, CFG_RANGE, 32'h0000_0100, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h0000_FFFF, 8'd0},
    '{ROW_WRITE, CFG_GAIN,  32'h0000_0000, 8'd0},
    '{ROW_CHECK, CFG_GAIN,  32'h00FF_FFFF, 8'd0},
    '{ROW_WRITE, CFG_GAIN,  32'hFFFF_FFFF, 8'd0},
    '{ROW_WRITE, CFG_NORM,  32'h0000_0001, 8'd0},
    '{ROW_CHECK, CFG_GAIN,  32'h0000_0001, 8'd255},
    '{ROW_WRITE, CFG_NORM,  32'h0000_0000, 8'd0},
    '{ROW_CHECK, CFG_GAIN,  32'h0000_0005, 8'd255},
    '{ROW_CHECK, CFG_GAIN,  32'h0000_0000, 8'd0},
    '{ROW_WRITE, CFG_GAIN,  32'h0000_0001, 8'd0},
    '{ROW_WRITE, CFG_NORM,  32'hFFFF_FFFF, 8'd0},
    '{ROW_WRITE, CFG_RANGE, 32'h0000_FFFF, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h0000_0001, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h00FF_FFFF, 8'd0},
    '{ROW_WRITE, CFG_SPARE, 32'h1234_5678, 8'd0},
    '{ROW_PIXEL, CFG_GAIN,  32'h0000_0FFF, 8'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // fields from bit 0: sample[23:0]
  logic [SAMPLE_W-1:0]   in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // fields from bit 0: pixel_value[7:0]
  logic [PIX_W-1:0]      out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GAIN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the registers
  logic [GAIN_W-1:0]     gain_q16 = GAIN_RST;
  logic [GAIN_W-1:0]     norm_q16 = NORM_RST;
  logic [RANGE_W-1:0]    range_q8 = RANGE_RST;

  logic [PIX_W-1:0]      pixel_due [$];
  bit                    steady = 1'b0;
  bit                    streaming = 1'b0;
  int                    fails = 0;
  int                    samples_sent = 0;
  int                    pixels_seen = 0;
  int                    grey_pixels = 0;
  int                    settings = 0;

  log_compress_pixel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Q16 log2: top set bit for the integer part, repeated squaring of the
  // normalized mantissa for 16 fraction bits
  function automatic longint log2_fix(input logic [63:0] v);
    int               top;
    logic [63:0]      mant;
    longint unsigned  frac;
    top = 63;
    while (top > 0 && v[top] == 1'b0) top--;
    if (top >= 31) mant = v >> (top - 31);
    else mant = v << (31 - top);
    mant &= 64'hFFFF_FFFF;
    frac = 0;
    repeat (FRAC_W) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        frac |= 1;
        mant = mant >> 1;
      end
    end
    return longint'(top) * 65536 + longint'(frac);
  endfunction

  // Grey level for one sample under the current register copy
  function automatic logic [PIX_W-1:0] grey_level(input logic [SAMPLE_W-1:0] s);
    logic [63:0] prod;
    longint      span, octaves, acc, level;
    prod = {32'd0, gain_q16} * {{(64 - SAMPLE_W){1'b0}}, s};
    span = (range_q8 == 0) ? 64'sd1 : longint'({48'd0, range_q8});
    if (prod == 0) return '0;
    if (norm_q16 == 0) return PIX_MAX;
    octaves = log2_fix(prod) - log2_fix({32'd0, norm_q16});
    acc = 255 * span * (64'sd1 <<< 32) + 65280 * octaves * DB_OCTAVE_Q16;
    if (acc < 0) return '0;
    level = acc / (span <<< 32);
    if (level > 255) return PIX_MAX;
    return level[PIX_W-1:0];
  endfunction

  task automatic flag_error(input string msg);
    fails++;
    if (fails <= MAX_SHOWN) $display("mismatch: %s", msg);
  endtask

  // Hold one register write for one edge; the next request lowers cfg_we
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_GAIN:  gain_q16 = val;
      CFG_NORM:  norm_q16 = val;
      CFG_RANGE: range_q8 = val[RANGE_W-1:0];
      default: ;
    endcase
  endtask

  // Drop valid and wait until every pending pixel has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pixel_due.size() != 0);
    streaming = 1'b0;
  endtask

  // Offer one sample, at random after a gap unless steady, and record its grey level
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input logic [PIX_W-1:0] typed_px);
    cfg_we <= 1'b0;
    if (!steady && $urandom_range(0, 99) < 36) begin
      in_tvalid <= 1'b0;
      in_tdata  <= SAMPLE_W'($urandom);
      do @(posedge clk); while ($urandom_range(0, 99) < 36);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixel_due.insert(pixel_due.size(), typed ? typed_px : grey_level(s));
    samples_sent++;
    streaming = 1'b1;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 36);
  end

  // Compare each pixel with the oldest pending grey level
  always @(posedge clk) begin
    logic [PIX_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      pixels_seen++;
      if (out_tdata != 0 && out_tdata != PIX_MAX) grey_pixels++;
      if (pixel_due.size() == 0) begin
        flag_error($sformatf("pixel %0d with nothing pending", out_tdata));
      end else begin
        want = pixel_due.pop_front();
        if (out_tdata != want)
          flag_error($sformatf("pixel_value expected %0d got %0d (pixel %0d)",
                               want, out_tdata, pixels_seen));
      end
    end
  end

  initial begin : stimulus
    row_t         row;
    logic [31:0]  g, n;
    logic [15:0]  r;
    logic [63:0]  wide;
    logic [SAMPLE_W-1:0] s;
    int           waited;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows
    foreach (PLAN[i]) begin
      row = PLAN[i];
      if (row.kind == ROW_WRITE) begin
        if (streaming) settle();
        cfg_write(row.index, row.value);
        settings++;
      end else begin
        send_sample(row.value[SAMPLE_W-1:0], row.kind == ROW_CHECK, row.pixel);
      end
    end

    // Random phases, one register setting each
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      steady = 1'b0;
      case ($urandom_range(0, 5))
        0:       g = 32'hFFFF_FFFF;
        1:       g = 32'd1;
        2:       g = GAIN_RST;
        default: g = $urandom >> $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 5))
        0:       n = 32'hFFFF_FFFF;
        1:       n = 32'd1;
        2:       n = $urandom >> $urandom_range(0, 31);
        default: begin
          // place 0 dB inside the sample span so grey levels come out
          wide = {32'd0, g} << $urandom_range(0, 24);
          n = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
        end
      endcase
      case ($urandom_range(0, 5))
        0:       r = 16'd0;
        1:       r = 16'd256;
        2:       r = 16'hFFFF;
        3:       r = 16'($urandom_range(256, 65535));
        default: r = 16'($urandom_range(5120, 25600));
      endcase
      cfg_write(CFG_GAIN, g);
      cfg_write(CFG_NORM, n);
      cfg_write(CFG_RANGE, {16'd0, r});
      settings++;
      steady = (ph == 2 || ph == 3);
      for (int k = 0; k < 100; k++) begin
        if (ph == 5 && k == 50) settle();
        case ($urandom_range(0, 19))
          0:       s = '0;
          1, 2, 3: s = SAMPLE_W'($urandom);
          default: s = SAMPLE_W'($urandom >> $urandom_range(8, 31));
        endcase
        send_sample(s, 1'b0, '0);
      end
    end

    // Drain, then watch for stray pixels over the pipe latency
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pixel_due.size() != 0 && waited < 20000);
    repeat (40) @(posedge clk);
    if (pixel_due.size() != 0)
      flag_error($sformatf("%0d pixels never came out", pixel_due.size()));

    $display("Sent %0d samples over %0d register settings, %0d pixels checked.",
             samples_sent, settings, pixels_seen);
    $display("%0d pixels fell strictly between black and white; %0d mismatches.",
             grey_pixels, fails);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
